// ===== design/adx_pkg.sv =====
`timescale 1ns / 1ps
package adx_pkg;

  localparam int PRICE_W        = 32;
  localparam int VAL_W          = 23;
  localparam int FRAC_W         = 16;
  localparam int RANGE_DAYS_DEF = 14;
  localparam int AVG_DAYS_DEF   = 6;

  // 100 percent with 16 fractional bits
  localparam logic [VAL_W-1:0] VAL_MAX = 23'd6553600;

  typedef struct packed {
    logic load_in;
    logic move;
    logic drop;
    logic add;
    logic prep;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_adx;
    logic dx_drop;
    logic dx_add;
    logic adx_push;
    logic out_load;
  } adx_cmd_t;

  typedef struct packed {
    logic first_bar;
    logic div_done;
  } adx_stat_t;

endpackage

// ===== design/directional_movement_adx.sv =====
// a new bar is not taken before the previous one has reached its result beat (the first
//   bar goes straight to it); the time per bar is set mostly by the 23-step
//   pass through the serial divider for dx; the adx mean is a reciprocal multiply
// a new bar is taken while the previous result beat still waits on out_ready
// reset (rst, synchronous): all history, window sums and day count cleared, no beat pending
`timescale 1ns / 1ps
module directional_movement_adx #(
  parameter int RANGE_DAYS = adx_pkg::RANGE_DAYS_DEF,
  parameter int AVG_DAYS   = adx_pkg::AVG_DAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [adx_pkg::PRICE_W-1:0] high_price,
  input  logic [adx_pkg::PRICE_W-1:0] low_price,
  input  logic [adx_pkg::PRICE_W-1:0] close_price,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        dx_valid,
  output logic [adx_pkg::VAL_W-1:0]   dx_value,
  output logic                        dx_undefined,
  output logic                        adx_valid,
  output logic [adx_pkg::VAL_W-1:0]   adx_value,
  output logic [adx_pkg::VAL_W-1:0]   adxr_value
);

  adx_pkg::adx_cmd_t  cmd;
  adx_pkg::adx_stat_t stat;

  adx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  adx_dp #(
    .RANGE_DAYS(RANGE_DAYS),
    .AVG_DAYS  (AVG_DAYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .high_price   (high_price),
    .low_price    (low_price),
    .close_price  (close_price),
    .dx_valid     (dx_valid),
    .dx_value     (dx_value),
    .dx_undefined (dx_undefined),
    .adx_valid    (adx_valid),
    .adx_value    (adx_value),
    .adxr_value   (adxr_value)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a bar is in progress");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dx_undefined) |-> (dx_valid && (dx_value == '0)))
    else $error("undefined dx with nonzero value");

  a_adx_needs_dx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && adx_valid) |-> dx_valid)
    else $error("adx valid before dx valid");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((dx_value <= adx_pkg::VAL_MAX) && (adx_value <= adx_pkg::VAL_MAX)
                   && (adxr_value <= adx_pkg::VAL_MAX)))
    else $error("index above one hundred percent");

endmodule

// ===== design/adx_div.sv =====
`timescale 1ns / 1ps
module adx_div #(
  parameter int DW = 37,
  parameter int QW = adx_pkg::VAL_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW+QW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [QW-1:0]    quotient,
  output logic             done
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   cat;
  logic [DW:0]   trial;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign cat   = {rem, low[QW-1]};
  assign ge    = (cat >= {1'b0, divisor});
  assign trial = cat - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DW+QW-1:QW];
      low <= dividend[QW-1:0];
    end else if (busy) begin
      rem <= ge ? trial[DW-1:0] : cat[DW-1:0];
      low <= {low[QW-2:0], ge};
    end
  end

  assign quotient = low;

endmodule

// ===== design/adx_dp.sv =====
`timescale 1ns / 1ps
module adx_dp #(
  parameter int RANGE_DAYS = adx_pkg::RANGE_DAYS_DEF,
  parameter int AVG_DAYS   = adx_pkg::AVG_DAYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  adx_pkg::adx_cmd_t            cmd,
  output adx_pkg::adx_stat_t           stat,
  input  logic [adx_pkg::PRICE_W-1:0]  high_price,
  input  logic [adx_pkg::PRICE_W-1:0]  low_price,
  input  logic [adx_pkg::PRICE_W-1:0]  close_price,
  output logic                         dx_valid,
  output logic [adx_pkg::VAL_W-1:0]    dx_value,
  output logic                         dx_undefined,
  output logic                         adx_valid,
  output logic [adx_pkg::VAL_W-1:0]    adx_value,
  output logic [adx_pkg::VAL_W-1:0]    adxr_value
);

  localparam int PW    = adx_pkg::PRICE_W;
  localparam int VW    = adx_pkg::VAL_W;
  localparam int SUM_W = PW + $clog2(RANGE_DAYS);
  localparam int DW    = SUM_W + 1;
  localparam int NW    = DW + VW;
  localparam int MW    = NW - adx_pkg::FRAC_W;
  localparam int CAP   = RANGE_DAYS + 2 * AVG_DAYS + 1;
  localparam int DC_W  = $clog2(CAP + 1);
  localparam int AS_W  = VW + $clog2(AVG_DAYS + 1);
  localparam int MEAN_SH = AS_W + $clog2(AVG_DAYS);
  localparam int RC_W    = AS_W + 1;
  localparam int MP_W    = AS_W + RC_W;
  localparam longint unsigned MEAN_RECIP =
    ((64'd1 << MEAN_SH) + 64'(AVG_DAYS) - 64'd1) / 64'(AVG_DAYS);

  logic [PW-1:0] in_high, in_low, in_close;
  logic [PW-1:0] last_high, last_low, last_close;
  logic [DC_W-1:0] day_count;
  logic [DC_W-1:0] dc_inc;
  logic dxok, adxok, undef;

  logic signed [PW:0] d_hl, d_hc, d_cl, up_raw, dn_raw;
  logic signed [PW:0] tr_max, up_c, dn_c;
  logic [PW-1:0] tr_sel, up_sel, dn_sel;
  logic [PW-1:0] tr_v, up_v, dn_v;

  logic [PW-1:0] range_ring [RANGE_DAYS];
  logic [PW-1:0] up_move_ring [RANGE_DAYS];
  logic [PW-1:0] down_move_ring [RANGE_DAYS];
  logic [SUM_W-1:0] sum_tr, sum_up, sum_dn;

  logic [DW-1:0] tot, diff;
  logic [MW-1:0] prod;

  logic [VW-1:0] dx_ring [AVG_DAYS];
  logic [VW-1:0] adx_ring [AVG_DAYS];
  logic [AS_W-1:0] adx_sum;
  logic [MP_W-1:0] mean_prod;
  logic [VW-1:0] adx_mean;
  logic [VW-1:0] dx_q, adx_q, adxr_q;
  logic [VW-1:0] dx_new, adx_new;
  logic [VW:0]   adxr_sum;

  logic [NW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic [VW-1:0] quotient;
  logic          div_done;

  assign dc_inc = (day_count < DC_W'(CAP)) ? day_count + DC_W'(1) : day_count;

  // true range and surviving move
  always_comb begin
    tr_max = d_hl;
    if (d_hc > tr_max) tr_max = d_hc;
    if (d_cl > tr_max) tr_max = d_cl;
    tr_sel = (tr_max < 0) ? '0 : tr_max[PW-1:0];
    up_c   = (up_raw < 0) ? '0 : up_raw;
    dn_c   = (dn_raw < 0) ? '0 : dn_raw;
    up_sel = (up_c > dn_c) ? up_c[PW-1:0] : '0;
    dn_sel = (dn_c > up_c) ? dn_c[PW-1:0] : '0;
  end

  assign adx_mean = mean_prod[MEAN_SH +: VW];

  assign dx_new   = (dxok && !undef) ? quotient : '0;
  assign adx_new  = adxok ? adx_mean : '0;
  assign adxr_sum = {1'b0, adx_new} + {1'b0, adx_ring[AVG_DAYS-1]};

  assign div_dividend = {prod, {adx_pkg::FRAC_W{1'b0}}};
  assign div_divisor  = tot;

  adx_div #(
    .DW(DW),
    .QW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign stat.first_bar = (day_count == '0);
  assign stat.div_done  = div_done;

  // state with defined reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_high  <= '0;
      last_low   <= '0;
      last_close <= '0;
      day_count  <= '0;
      sum_tr     <= '0;
      sum_up     <= '0;
      sum_dn     <= '0;
      adx_sum    <= '0;
      for (int i = 0; i < RANGE_DAYS; i++) begin
        range_ring[i]     <= '0;
        up_move_ring[i]   <= '0;
        down_move_ring[i] <= '0;
      end
      for (int i = 0; i < AVG_DAYS; i++) begin
        dx_ring[i]  <= '0;
        adx_ring[i] <= '0;
      end
    end else begin
      if (cmd.move) begin
        last_high  <= in_high;
        last_low   <= in_low;
        last_close <= in_close;
        day_count  <= dc_inc;
      end
      if (cmd.drop) begin
        sum_tr <= sum_tr - SUM_W'(range_ring[RANGE_DAYS-1]);
        sum_up <= sum_up - SUM_W'(up_move_ring[RANGE_DAYS-1]);
        sum_dn <= sum_dn - SUM_W'(down_move_ring[RANGE_DAYS-1]);
      end
      if (cmd.add) begin
        sum_tr <= sum_tr + SUM_W'(tr_v);
        sum_up <= sum_up + SUM_W'(up_v);
        sum_dn <= sum_dn + SUM_W'(dn_v);
        range_ring[0]     <= tr_v;
        up_move_ring[0]   <= up_v;
        down_move_ring[0] <= dn_v;
        for (int i = 1; i < RANGE_DAYS; i++) begin
          range_ring[i]     <= range_ring[i-1];
          up_move_ring[i]   <= up_move_ring[i-1];
          down_move_ring[i] <= down_move_ring[i-1];
        end
      end
      if (cmd.dx_drop) begin
        adx_sum <= adx_sum - AS_W'(dx_ring[AVG_DAYS-1]);
      end
      if (cmd.dx_add) begin
        adx_sum    <= adx_sum + AS_W'(dx_new);
        dx_ring[0] <= dx_new;
        for (int i = 1; i < AVG_DAYS; i++) begin
          dx_ring[i] <= dx_ring[i-1];
        end
      end
      if (cmd.adx_push) begin
        adx_ring[0] <= adx_new;
        for (int i = 1; i < AVG_DAYS; i++) begin
          adx_ring[i] <= adx_ring[i-1];
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_high  <= high_price;
      in_low   <= low_price;
      in_close <= close_price;
    end
    if (cmd.move) begin
      d_hl   <= $signed({1'b0, in_high}) - $signed({1'b0, in_low});
      d_hc   <= $signed({1'b0, in_high}) - $signed({1'b0, last_close});
      d_cl   <= $signed({1'b0, last_close}) - $signed({1'b0, in_low});
      up_raw <= $signed({1'b0, in_high}) - $signed({1'b0, last_high});
      dn_raw <= $signed({1'b0, last_low}) - $signed({1'b0, in_low});
      if (day_count == '0) begin
        dxok  <= 1'b0;
        adxok <= 1'b0;
      end else begin
        dxok  <= (dc_inc >= DC_W'(RANGE_DAYS + 1));
        adxok <= (dc_inc >= DC_W'(RANGE_DAYS + AVG_DAYS + 1));
      end
    end
    if (cmd.drop) begin
      tr_v <= tr_sel;
      up_v <= up_sel;
      dn_v <= dn_sel;
    end
    if (cmd.prep) begin
      tot   <= DW'(sum_up) + DW'(sum_dn);
      diff  <= (sum_up >= sum_dn) ? DW'(sum_up - sum_dn) : DW'(sum_dn - sum_up);
      undef <= (sum_tr == '0) || ((sum_up == '0) && (sum_dn == '0));
    end
    // diff * 100 as shifted adds
    if (cmd.mul1) begin
      prod <= MW'({diff, 6'b0}) + MW'({diff, 5'b0});
    end
    if (cmd.mul2) begin
      prod <= prod + MW'({diff, 2'b0});
    end
    // mean of the dx window by reciprocal multiply
    if (cmd.div_adx) begin
      mean_prod <= MP_W'(adx_sum) * MP_W'(MEAN_RECIP);
    end
    if (cmd.dx_add) begin
      dx_q <= dx_new;
    end
    if (cmd.adx_push) begin
      adx_q  <= adx_new;
      adxr_q <= adxok ? adxr_sum[VW:1] : '0;
    end
    if (cmd.out_load) begin
      dx_valid     <= dxok;
      dx_value     <= dxok ? dx_q : '0;
      dx_undefined <= dxok && undef;
      adx_valid    <= adxok;
      adx_value    <= adxok ? adx_q : '0;
      adxr_value   <= adxok ? adxr_q : '0;
    end
  end

endmodule

// ===== design/adx_ctrl.sv =====
`timescale 1ns / 1ps
module adx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output adx_pkg::adx_cmd_t  cmd,
  input  adx_pkg::adx_stat_t stat
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MOVE    = 4'd1;
  localparam logic [3:0] ST_DROP    = 4'd2;
  localparam logic [3:0] ST_ADD     = 4'd3;
  localparam logic [3:0] ST_PREP    = 4'd4;
  localparam logic [3:0] ST_MUL1    = 4'd5;
  localparam logic [3:0] ST_MUL2    = 4'd6;
  localparam logic [3:0] ST_DXDIV   = 4'd7;
  localparam logic [3:0] ST_DXWAIT  = 4'd8;
  localparam logic [3:0] ST_DXDROP  = 4'd9;
  localparam logic [3:0] ST_DXADD   = 4'd10;
  localparam logic [3:0] ST_ADXDIV  = 4'd11;
  localparam logic [3:0] ST_ADXPUSH = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd.move   = 1'b1;
        state_next = stat.first_bar ? ST_DONE : ST_DROP;
      end
      ST_DROP: begin
        cmd.drop   = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_DXDIV;
      end
      ST_DXDIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DXWAIT;
      end
      ST_DXWAIT: begin
        if (stat.div_done) state_next = ST_DXDROP;
      end
      ST_DXDROP: begin
        cmd.dx_drop = 1'b1;
        state_next  = ST_DXADD;
      end
      ST_DXADD: begin
        cmd.dx_add = 1'b1;
        state_next = ST_ADXDIV;
      end
      ST_ADXDIV: begin
        cmd.div_adx = 1'b1;
        state_next  = ST_ADXPUSH;
      end
      ST_ADXPUSH: begin
        cmd.adx_push = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
